/* hdl/spinor_pkg.sv */
package spinor_pkg;

  // Array geometry.
  localparam int FLASH_ADDR_BITS  = 20;
  localparam int SECTOR_ADDR_BITS = 16;
  localparam int PAGE_ADDR_BITS   = 8;
  localparam int PAGE_BYTES       = 1 << PAGE_ADDR_BITS;

  localparam logic [7:0]  ERASED      = 8'hFF;
  localparam logic [7:0]  SR_WRITE_EN = 8'h02;
  localparam logic [23:0] ID_RESET    = 24'hEF4018;

  // Request codes.
  localparam logic [1:0] REQ_SELECT   = 2'd0;
  localparam logic [1:0] REQ_XFER     = 2'd1;
  localparam logic [1:0] REQ_DESELECT = 2'd2;

  // Opcodes.
  localparam logic [7:0] OP_READ_ID  = 8'h9F;
  localparam logic [7:0] OP_SFDP     = 8'h5A;
  localparam logic [7:0] OP_STATUS   = 8'h05;
  localparam logic [7:0] OP_WREN     = 8'h06;
  localparam logic [7:0] OP_READ     = 8'h03;
  localparam logic [7:0] OP_PROG     = 8'h02;
  localparam logic [7:0] OP_SECT     = 8'hD8;
  localparam logic [7:0] OP_CHIP     = 8'hC7;

  localparam logic [7:0] SFDP_HEAD [16] = '{
    8'h53, 8'h46, 8'h44, 8'h50, 8'h05, 8'h01, 8'h00, 8'hff,
    8'h00, 8'h05, 8'h01, 8'h10, 8'h80, 8'h00, 8'h00, 8'hff
  };

  localparam logic [7:0] SFDP_PARAM [64] = '{
    8'he5, 8'h20, 8'hf9, 8'hff, 8'hff, 8'hff, 8'hff, 8'h07,
    8'h44, 8'heb, 8'h08, 8'h6b, 8'h08, 8'h3b, 8'h42, 8'hbb,
    8'hfe, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00,
    8'hff, 8'hff, 8'h40, 8'heb, 8'h0c, 8'h20, 8'h0f, 8'h52,
    8'h10, 8'hd8, 8'h00, 8'h00, 8'h36, 8'h02, 8'ha6, 8'h00,
    8'h82, 8'hea, 8'h14, 8'hc9, 8'he9, 8'h63, 8'h76, 8'h33,
    8'h7a, 8'h75, 8'h7a, 8'h75, 8'hf7, 8'ha2, 8'hd5, 8'h5c,
    8'h19, 8'hf7, 8'h4d, 8'hff, 8'he9, 8'h30, 8'hf8, 8'h80
  };

  // Discoverable parameter ROM: header, then the parameter table at 80h.
  function automatic logic [7:0] sfdp_byte(input logic [7:0] a);
    logic [7:0] r;
    if (a[7:4] == 4'h0) begin
      r = SFDP_HEAD[a[3:0]];
    end else if (a[7:6] == 2'b10) begin
      r = SFDP_PARAM[a[5:0]];
    end else begin
      r = ERASED;
    end
    return r;
  endfunction

endpackage

/* hdl/spi_nor_flash_device.sv */
// Serial NOR flash device model. Each request (select, byte transfer or
// deselect) is taken when start is high and busy is low, and gives exactly one
// result on miso_byte and write_enabled, marked by done for one cycle; the
// result cannot be held off. Select, transfer and most deselects are registered
// into an execute state, from which done is registered. A committing deselect
// walks the array through its RAM of one write and one read port: page program
// is a read-modify-write with one byte per cycle, sector erase walks the sector
// and chip erase the whole array. After reset the array is erased by the same
// walk, during which busy stays high; the ID register can be written at any
// time.
module spi_nor_flash_device
  import spinor_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [7:0]  mosi_byte,
  output logic        done,
  output logic [7:0]  miso_byte,
  output logic        write_enabled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  localparam int FA = FLASH_ADDR_BITS;
  localparam int SA = SECTOR_ADDR_BITS;
  localparam int PA = PAGE_ADDR_BITS;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_PROG, S_WIPE} state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_ID, CMD_SFDP, CMD_STATUS, CMD_WREN,
    CMD_READ, CMD_PROG, CMD_SECT, CMD_CHIP, CMD_OTHER
  } cmd_t;

  state_t          state;
  logic [1:0]      req_q;
  logic [7:0]      mosi_q;
  logic [23:0]     id_bytes;
  logic            selected;
  cmd_t            cmd;
  logic [23:0]     byte_address;
  logic [1:0]      addr_seen;
  logic [1:0]      reply_index;
  logic            write_latch;
  logic [PA-1:0]   page_offset;
  logic            data_received;
  logic [PAGE_BYTES-1:0] pvalid;
  logic            pv_q;
  logic [PA:0]     pcnt;
  logic [FA-1:0]   cnt;
  logic [FA-1:0]   cnt_last;
  logic [FA-1:0]   wipe_base;
  logic            wipe_reply;

  logic [23:0]     addr_shift;
  logic [23:0]     addr_taken;
  logic [FA-1:0]   pg_start;
  logic [PA-1:0]   pcnt_prev;

  logic            flash_we;
  logic [FA-1:0]   flash_waddr;
  logic [7:0]      flash_wdata;
  logic [FA-1:0]   flash_raddr;
  logic [7:0]      flash_rdata;
  logic            pbuf_we;
  logic [7:0]      pbuf_rdata;

  cmd_t            decoded;

  assign busy          = (state != S_IDLE);
  assign cfg_ready     = 1'b1;
  assign write_enabled = write_latch;

  // Address byte shifting; the third byte reduces the address to the array size.
  assign addr_shift = {byte_address[15:0], mosi_q};
  assign addr_taken = (addr_seen == 2'd2) ? 24'(addr_shift[FA-1:0]) : addr_shift;
  assign pg_start   = {byte_address[FA-1:PA], PA'(0)};
  assign pcnt_prev  = PA'(pcnt - 1'b1);

  // Opcode decode.
  always_comb begin
    case (mosi_q)
      OP_READ_ID: decoded = CMD_ID;
      OP_SFDP:    decoded = CMD_SFDP;
      OP_STATUS:  decoded = CMD_STATUS;
      OP_WREN:    decoded = CMD_WREN;
      OP_READ:    decoded = CMD_READ;
      OP_PROG:    decoded = CMD_PROG;
      OP_SECT:    decoded = CMD_SECT;
      OP_CHIP:    decoded = CMD_CHIP;
      default:    decoded = CMD_OTHER;
    endcase
  end

  // Array port control: the walks own the port, otherwise it reads at the address.
  always_comb begin
    flash_we    = 1'b0;
    flash_waddr = cnt | wipe_base;
    flash_wdata = ERASED;
    flash_raddr = byte_address[FA-1:0];
    case (state)
      S_WIPE: begin
        flash_we = 1'b1;
      end
      S_PROG: begin
        flash_raddr = pg_start | FA'(pcnt[PA-1:0]);
        flash_we    = (pcnt != '0);
        flash_waddr = pg_start | FA'(pcnt_prev);
        flash_wdata = flash_rdata & (pv_q ? pbuf_rdata : ERASED);
      end
      default: begin
      end
    endcase
  end

  // A data byte of a page program goes into the page buffer.
  assign pbuf_we = (state == S_EXEC) && (req_q == REQ_XFER) && selected &&
                   (cmd == CMD_PROG) && (addr_seen == 2'd3);

  spinor_ram #(.WIDTH(8), .DEPTH(1 << FA)) u_flash (
    .clk   (clk),
    .we    (flash_we),
    .waddr (flash_waddr),
    .wdata (flash_wdata),
    .raddr (flash_raddr),
    .rdata (flash_rdata)
  );

  spinor_ram #(.WIDTH(8), .DEPTH(PAGE_BYTES)) u_pbuf (
    .clk   (clk),
    .we    (pbuf_we),
    .waddr (page_offset),
    .wdata (mosi_q),
    .raddr (pcnt[PA-1:0]),
    .rdata (pbuf_rdata)
  );

  // ID register.
  always_ff @(posedge clk) begin
    if (rst) begin
      id_bytes <= ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      id_bytes <= cfg_data;
    end
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_WIPE;
      done          <= 1'b0;
      miso_byte     <= ERASED;
      selected      <= 1'b0;
      cmd           <= CMD_NONE;
      byte_address  <= '0;
      addr_seen     <= '0;
      reply_index   <= '0;
      write_latch   <= 1'b0;
      page_offset   <= '0;
      data_received <= 1'b0;
      pvalid        <= '0;
      pcnt          <= '0;
      cnt           <= '0;
      cnt_last      <= '1;
      wipe_base     <= '0;
      wipe_reply    <= 1'b0;
      req_q         <= REQ_SELECT;
      mosi_q        <= '0;
      pv_q          <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_q  <= req_type;
            mosi_q <= mosi_byte;
            state  <= S_EXEC;
          end
        end

        S_EXEC: begin
          miso_byte <= ERASED;
          done      <= 1'b1;
          state     <= S_IDLE;
          case (req_q)
            REQ_SELECT: begin
              selected      <= 1'b1;
              cmd           <= CMD_NONE;
              byte_address  <= '0;
              addr_seen     <= '0;
              reply_index   <= '0;
              page_offset   <= '0;
              data_received <= 1'b0;
              pvalid        <= '0;
            end
            REQ_XFER: begin
              if (!selected) begin
                // Ignored while deselected.
              end else if (cmd == CMD_NONE) begin
                cmd <= decoded;
              end else begin
                case (cmd)
                  CMD_ID: begin
                    if (reply_index != 2'd3) begin
                      case (reply_index)
                        2'd0:    miso_byte <= id_bytes[23:16];
                        2'd1:    miso_byte <= id_bytes[15:8];
                        default: miso_byte <= id_bytes[7:0];
                      endcase
                      reply_index <= reply_index + 2'd1;
                    end
                  end
                  CMD_SFDP: begin
                    if (addr_seen != 2'd3) begin
                      byte_address <= addr_taken;
                      addr_seen    <= addr_seen + 2'd1;
                    end else if (reply_index == 2'd0) begin
                      reply_index <= 2'd1;
                    end else if (byte_address[23:8] == '0) begin
                      miso_byte    <= sfdp_byte(byte_address[7:0]);
                      byte_address <= byte_address + 24'd1;
                    end
                  end
                  CMD_STATUS: begin
                    miso_byte <= write_latch ? SR_WRITE_EN : 8'h00;
                  end
                  CMD_READ: begin
                    if (addr_seen != 2'd3) begin
                      byte_address <= addr_taken;
                      addr_seen    <= addr_seen + 2'd1;
                    end else begin
                      miso_byte    <= flash_rdata;
                      byte_address <= 24'(FA'(byte_address[FA-1:0] + 1'b1));
                    end
                  end
                  CMD_PROG: begin
                    if (addr_seen != 2'd3) begin
                      byte_address <= addr_taken;
                      addr_seen    <= addr_seen + 2'd1;
                      if (addr_seen == 2'd2) begin
                        page_offset <= addr_taken[PA-1:0];
                      end
                    end else begin
                      pvalid[page_offset] <= 1'b1;
                      page_offset         <= page_offset + 1'b1;
                      data_received       <= 1'b1;
                    end
                  end
                  CMD_SECT: begin
                    if (addr_seen != 2'd3) begin
                      byte_address <= addr_taken;
                      addr_seen    <= addr_seen + 2'd1;
                    end
                  end
                  default: begin
                  end
                endcase
              end
            end
            REQ_DESELECT: begin
              if (selected) begin
                selected      <= 1'b0;
                cmd           <= CMD_NONE;
                byte_address  <= '0;
                addr_seen     <= '0;
                reply_index   <= '0;
                page_offset   <= '0;
                data_received <= 1'b0;
                pvalid        <= '0;
                case (cmd)
                  CMD_WREN: begin
                    write_latch <= 1'b1;
                  end
                  CMD_PROG: begin
                    if (write_latch && addr_seen == 2'd3 && data_received) begin
                      // Keep address and buffer until the page is written.
                      byte_address <= byte_address;
                      pvalid       <= pvalid;
                      pcnt         <= '0;
                      done         <= 1'b0;
                      state        <= S_PROG;
                    end
                  end
                  CMD_SECT: begin
                    if (write_latch && addr_seen == 2'd3) begin
                      wipe_base  <= {byte_address[FA-1:SA], SA'(0)};
                      cnt        <= '0;
                      cnt_last   <= FA'((1 << SA) - 1);
                      wipe_reply <= 1'b1;
                      done       <= 1'b0;
                      state      <= S_WIPE;
                    end
                  end
                  CMD_CHIP: begin
                    if (write_latch) begin
                      wipe_base  <= '0;
                      cnt        <= '0;
                      cnt_last   <= '1;
                      wipe_reply <= 1'b1;
                      done       <= 1'b0;
                      state      <= S_WIPE;
                    end
                  end
                  default: begin
                  end
                endcase
              end
            end
            default: begin
            end
          endcase
        end

        // Read-modify-write of one page, one byte per cycle.
        S_PROG: begin
          pv_q <= pvalid[pcnt[PA-1:0]];
          pcnt <= pcnt + 1'b1;
          if (pcnt[PA]) begin
            write_latch  <= 1'b0;
            byte_address <= '0;
            pvalid       <= '0;
            miso_byte    <= ERASED;
            done         <= 1'b1;
            state        <= S_IDLE;
          end
        end

        // Erase walk; also the clearing pass after reset.
        S_WIPE: begin
          cnt <= cnt + 1'b1;
          if (cnt == cnt_last) begin
            state <= S_IDLE;
            if (wipe_reply) begin
              write_latch <= 1'b0;
              miso_byte   <= ERASED;
              done        <= 1'b1;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted request makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // A result is only shown once the sequencer is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("done outside idle");

  // The array is written only by the walks.
  a_we_walk: assert property (@(posedge clk) disable iff (rst)
    flash_we |-> (state == S_WIPE || state == S_PROG))
    else $error("array write outside a walk");

  // The latch clears only as a committing request completes.
  a_wel_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(write_latch) |-> done)
    else $error("write latch cleared without a result");

  // The page buffer is written only while selected and in a program.
  a_pbuf_prog: assert property (@(posedge clk) disable iff (rst)
    pbuf_we |-> (selected && cmd == CMD_PROG))
    else $error("page buffer written outside program");

endmodule

/* hdl/spinor_ram.sv */
module spinor_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
